>>> design/wfpa_pkg.sv
// ----------------------------------------------------------------------------
// wfpa_pkg - shared types and constants of the worst-fit partition allocator
// Field widths, status codes, parameter defaults, and the records that are
// passed along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none
package wfpa_pkg;

  localparam int MAX_PARTS_DEF    = 16;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int SIZE_W = 21;  // partition data size and heap size
  localparam int ADDR_W = 20;  // heap offsets
  localparam int RND_W  = 22;  // rounded request, can reach 2^21

  localparam logic [SIZE_W-1:0] HEAP_MIN   = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] HEAP_MAX   = SIZE_W'(1048576);
  localparam logic [SIZE_W-1:0] HEAP_RESET = SIZE_W'(4096);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // search record handed from cell to cell
  typedef struct packed {
    logic              hit;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] start;
  } wfpa_rec_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              op;
    logic [RND_W-1:0]  rounded;
    logic [ADDR_W-1:0] addr;
    logic              upd;
    logic              split;
    logic [ADDR_W-1:0] hole_start;
    logic [SIZE_W-1:0] hole_size;
    logic              init;
    logic [SIZE_W-1:0] init_size;
  } wfpa_ctl_t;

endpackage
`default_nettype wire

>>> design/wfpa_if.sv
// ----------------------------------------------------------------------------
// wfpa interfaces - request, response and configuration channels
// Valid/ready channels carrying the allocator payloads.
// ----------------------------------------------------------------------------
`default_nettype none
interface wfpa_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [20:0] request_size;
  logic [19:0] block_address;
  modport source (output valid, op, request_size, block_address, input ready);
  modport sink   (input valid, op, request_size, block_address, output ready);
endinterface

interface wfpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] data_offset;
  modport source (output valid, status, data_offset, input ready);
  modport sink   (input valid, status, data_offset, output ready);
endinterface

interface wfpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> design/wfpa_cell.sv
// ----------------------------------------------------------------------------
// wfpa_cell - one partition table entry
// Holds start, size and busy flag, refines the search record from its left
// neighbour each cycle, and shifts right when a hole is inserted before it.
// ----------------------------------------------------------------------------
`default_nettype none
module wfpa_cell #(
  parameter int CELL_IDX     = 0,
  parameter int IDXW         = 4,
  parameter int HEADER_BYTES = 16
) (
  input  wire                               clk,
  input  wfpa_pkg::wfpa_ctl_t               ctl,
  input  wire                               active,
  input  wire  [IDXW-1:0]                   tgt_idx,
  input  wfpa_pkg::wfpa_rec_t               left_rec,
  input  wire  [IDXW-1:0]                   left_idx,
  input  wire  [wfpa_pkg::ADDR_W-1:0]       left_start,
  input  wire  [wfpa_pkg::SIZE_W-1:0]       left_size,
  input  wire                               left_busy,
  output wfpa_pkg::wfpa_rec_t               rec,
  output logic [IDXW-1:0]                   rec_idx,
  output logic [wfpa_pkg::ADDR_W-1:0]       start,
  output logic [wfpa_pkg::SIZE_W-1:0]       size,
  output logic                              busy
);
  import wfpa_pkg::*;

  localparam logic [IDXW:0] MY_IDX = (IDXW+1)'(CELL_IDX);

  logic             cand;
  logic             take;
  logic [ADDR_W:0]  data_ofs;
  logic [IDXW:0]    tgt_ext;

  // candidate test for this entry
  always_comb begin
    data_ofs = {1'b0, start} + (ADDR_W+1)'(HEADER_BYTES);
    tgt_ext  = {1'b0, tgt_idx};
    if (ctl.op == OP_ALLOC) begin
      cand = active && !busy && ({1'b0, size} >= ctl.rounded);
      take = cand && (!left_rec.hit || (size > left_rec.size));
    end else begin
      cand = active && (data_ofs == {1'b0, ctl.addr});
      take = cand && !left_rec.hit;
    end
  end

  // search record stage
  always_ff @(posedge clk) begin
    if (take) begin
      rec.hit   <= 1'b1;
      rec.size  <= size;
      rec.start <= start;
      rec_idx   <= IDXW'(CELL_IDX);
    end else begin
      rec     <= left_rec;
      rec_idx <= left_idx;
    end
  end

  // entry update
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      if (CELL_IDX == 0) begin
        start <= '0;
        size  <= ctl.init_size;
        busy  <= 1'b0;
      end
    end else if (ctl.upd) begin
      if (ctl.op == OP_FREE) begin
        if (MY_IDX == tgt_ext) busy <= 1'b0;
      end else begin
        if (MY_IDX == tgt_ext) begin
          busy <= 1'b1;
          if (ctl.split) size <= ctl.rounded[SIZE_W-1:0];
        end else if (ctl.split && (MY_IDX == tgt_ext + 1'b1)) begin
          start <= ctl.hole_start;
          size  <= ctl.hole_size;
          busy  <= 1'b0;
        end else if (ctl.split && (MY_IDX > tgt_ext + 1'b1)) begin
          start <= left_start;
          size  <= left_size;
          busy  <= left_busy;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/worst_fit_partition_allocator.sv
// Operation: a request is accepted only in the idle state, the search record
// then ripples through the whole row of MAX_PARTS cells before the update
// state, and no new request is taken until the response has been registered.
// Reset: synchronous, heap_size 4096, one free partition at offset 0.
// A heap_size write reinitialises the table.
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator - worst-fit heap partition table
// Row of table cells with a search record passed along it, plus a sequencer
// that rounds requests, decides the split and returns the response.
// ----------------------------------------------------------------------------
`default_nettype none
module worst_fit_partition_allocator #(
  parameter int MAX_PARTS    = wfpa_pkg::MAX_PARTS_DEF,
  parameter int HEADER_BYTES = wfpa_pkg::HEADER_BYTES_DEF
) (
  input wire           clk,
  input wire           rst,
  wfpa_req_if.sink     req,
  wfpa_rsp_if.source   rsp,
  wfpa_cfg_if.sink     cfg
);
  import wfpa_pkg::*;

  localparam int IDXW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW   = $clog2(MAX_PARTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} state_t;

  state_t             state;
  logic [CW-1:0]      scan_cnt;
  logic [CW-1:0]      count;
  logic               op;
  logic [RND_W-1:0]   rounded;
  logic [ADDR_W-1:0]  addr;
  logic               rsp_valid;
  logic [1:0]         rsp_status;
  logic [ADDR_W-1:0]  rsp_ofs;

  wfpa_ctl_t          ctl;
  wfpa_rec_t          rec   [MAX_PARTS];
  logic [IDXW-1:0]    ridx  [MAX_PARTS];
  logic [ADDR_W-1:0]  cstart[MAX_PARTS];
  logic [SIZE_W-1:0]  csize [MAX_PARTS];
  logic               cbusy [MAX_PARTS];

  logic [RND_W-1:0]   req_rnd;
  logic [SIZE_W-1:0]  cfg_heap;
  logic               cfg_wr;
  logic               go;
  logic               split;
  wfpa_rec_t          best;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.data_offset = rsp_ofs;

  // request rounding, heap clamping, split decision
  always_comb begin
    if (req.request_size == '0) req_rnd = RND_W'(4);
    else req_rnd = ({1'b0, req.request_size} + RND_W'(3)) & ~RND_W'(3);
    if (cfg.data < HEAP_MIN) cfg_heap = HEAP_MIN;
    else if (cfg.data > HEAP_MAX) cfg_heap = HEAP_MAX;
    else cfg_heap = cfg.data;
    cfg_wr = cfg.valid;
    best   = rec[MAX_PARTS-1];
    go     = (state == S_UPD) && (!rsp_valid || rsp.ready);
    split  = ({2'b00, best.size} >= ({1'b0, rounded} + (RND_W+1)'(HEADER_BYTES + 4)))
             && (count < CW'(MAX_PARTS));
  end

  // broadcast control
  always_comb begin
    ctl.op         = op;
    ctl.rounded    = rounded;
    ctl.addr       = addr;
    ctl.upd        = go && best.hit;
    ctl.split      = split;
    ctl.hole_start = ADDR_W'({1'b0, best.start} + (ADDR_W+1)'(HEADER_BYTES)
                             + rounded[ADDR_W:0]);
    ctl.hole_size  = SIZE_W'({1'b0, best.size} - (RND_W)'(HEADER_BYTES) - rounded);
    ctl.init       = rst || cfg_wr;
    if (rst) ctl.init_size = HEAP_RESET - SIZE_W'(HEADER_BYTES);
    else if (cfg_heap > SIZE_W'(HEADER_BYTES)) ctl.init_size = cfg_heap - SIZE_W'(HEADER_BYTES);
    else ctl.init_size = '0;
  end

  // row of cells
  for (genvar k = 0; k < MAX_PARTS; k++) begin : g_cell
    wfpa_rec_t          lrec;
    logic [IDXW-1:0]    lidx;
    logic [ADDR_W-1:0]  lstart;
    logic [SIZE_W-1:0]  lsize;
    logic               lbusy;
    if (k == 0) begin : g_head
      assign lrec   = '0;
      assign lidx   = '0;
      assign lstart = '0;
      assign lsize  = '0;
      assign lbusy  = 1'b0;
    end else begin : g_link
      assign lrec   = rec[k-1];
      assign lidx   = ridx[k-1];
      assign lstart = cstart[k-1];
      assign lsize  = csize[k-1];
      assign lbusy  = cbusy[k-1];
    end
    wfpa_cell #(
      .CELL_IDX(k), .IDXW(IDXW), .HEADER_BYTES(HEADER_BYTES)
    ) u_cell (
      .clk(clk), .ctl(ctl), .active(count > CW'(k)),
      .tgt_idx(ridx[MAX_PARTS-1]),
      .left_rec(lrec), .left_idx(lidx),
      .left_start(lstart), .left_size(lsize), .left_busy(lbusy),
      .rec(rec[k]), .rec_idx(ridx[k]),
      .start(cstart[k]), .size(csize[k]), .busy(cbusy[k])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      count     <= CW'(1);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      if (cfg_wr) count <= CW'(1);
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op       <= req.op;
            rounded  <= req_rnd;
            addr     <= req.block_address;
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == CW'(MAX_PARTS - 1)) state <= S_UPD;
        end
        S_UPD: begin
          if (go) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
            if (!best.hit) begin
              rsp_status <= (op == OP_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
              rsp_ofs    <= '0;
            end else if (op == OP_FREE) begin
              rsp_status <= ST_OK;
              rsp_ofs    <= '0;
            end else begin
              rsp_status <= ST_OK;
              rsp_ofs    <= best.start + ADDR_W'(HEADER_BYTES);
              if (split) count <= count + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/worst_fit_partition_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator_test - self-checking bench for the allocator
// Requests come from a queue into a clocked driver. A local table model
// predicts status and offset for every accepted request, and a clocked
// monitor checks each response in order. Phases between heap_size writes
// mix directed cases, random allocate/free traffic, stalls and idle gaps.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator_test;
  import wfpa_pkg::*;

  localparam int PARTS = MAX_PARTS_DEF;
  localparam int HDR   = HEADER_BYTES_DEF;

  typedef struct {
    logic        op;
    logic [20:0] size;
    logic [19:0] addr;
  } heap_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [19:0] offset;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wfpa_req_if req ();
  wfpa_rsp_if rsp ();
  wfpa_cfg_if cfg ();

  worst_fit_partition_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the partition table
  int unsigned heap_bytes;
  int unsigned tbl_start [PARTS];
  int unsigned tbl_size  [PARTS];
  bit          tbl_busy  [PARTS];
  int unsigned tbl_count;

  heap_req_t pending_reqs[$];
  grant_t    expected_grants[$];

  int  sent_cnt = 0, taken_cnt = 0;
  int  errors = 0;
  int  n_ok = 0, n_nofit = 0, n_notfound = 0, n_frees = 0, n_full = 0;
  bit  calm = 1'b0;
  bit  hold_trigger = 1'b0;
  int  send_gap = 0, recv_gap = 0, hold_cnt = 0;

  function automatic void reset_table(input int unsigned value);
    int unsigned v;
    v = value & 32'h1FFFFF;
    if (v < HEAP_MIN) v = HEAP_MIN;
    if (v > HEAP_MAX) v = HEAP_MAX;
    heap_bytes = v;
    for (int i = 0; i < PARTS; i++) begin
      tbl_start[i] = 0;
      tbl_size[i]  = 0;
      tbl_busy[i]  = 1'b0;
    end
    tbl_size[0] = (v > HDR) ? v - HDR : 0;
    tbl_count   = 1;
  endfunction

  // worst-fit allocate or free against the local table
  function automatic grant_t predict_grant(input heap_req_t r);
    grant_t      g;
    int unsigned rnd, best;
    bit          found;
    g.status = ST_OK;
    g.offset = '0;
    best  = 0;
    found = 1'b0;
    if (r.op == OP_ALLOC) begin
      rnd = (r.size == 0) ? 4 : ((int'(r.size) + 3) & ~32'd3);
      for (int i = 0; i < tbl_count; i++) begin
        if (!tbl_busy[i] && tbl_size[i] >= rnd &&
            (!found || tbl_size[i] > tbl_size[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        g.status = ST_NO_FIT;
      end else begin
        if (tbl_size[best] >= rnd + HDR + 4) begin
          if (tbl_count < PARTS) begin
            for (int j = tbl_count; j > best + 1; j--) begin
              tbl_start[j] = tbl_start[j-1];
              tbl_size[j]  = tbl_size[j-1];
              tbl_busy[j]  = tbl_busy[j-1];
            end
            tbl_start[best+1] = tbl_start[best] + HDR + rnd;
            tbl_size[best+1]  = tbl_size[best] - HDR - rnd;
            tbl_busy[best+1]  = 1'b0;
            tbl_size[best]    = rnd;
            tbl_count++;
          end else begin
            n_full++;
          end
        end
        tbl_busy[best] = 1'b1;
        g.offset = 20'(tbl_start[best] + HDR);
      end
    end else begin
      g.status = ST_NOT_FOUND;
      for (int i = 0; i < tbl_count; i++) begin
        if (!found && tbl_start[i] + HDR == r.addr) begin
          tbl_busy[i] = 1'b0;
          g.status = ST_OK;
          found = 1'b1;
        end
      end
    end
    return g;
  endfunction

  // request driver, changes at the falling edge
  always @(negedge clk) begin
    heap_req_t r;
    if (!rst && sent_cnt == taken_cnt) begin
      if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 12);
        req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        req.op            <= r.op;
        req.request_size  <= r.size;
        req.block_address <= r.addr;
        req.valid         <= 1'b1;
        sent_cnt++;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // response receiver: random back-pressure and one long hold-off
  always @(negedge clk) begin
    if (hold_trigger) begin
      hold_trigger = 1'b0;
      hold_cnt = 300;
    end
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      rsp.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      rsp.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 12);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check responses in order
  always @(posedge clk) begin
    heap_req_t r;
    grant_t    g;
    if (!rst) begin
      if (req.valid && req.ready) begin
        r.op   = req.op;
        r.size = req.request_size;
        r.addr = req.block_address;
        expected_grants.push_back(predict_grant(r));
        taken_cnt++;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected response status=%0d offset=%0h", $time,
                   rsp.status, rsp.data_offset);
          errors++;
        end else begin
          g = expected_grants.pop_front();
          if (rsp.status !== g.status) begin
            $display("%0t: status expected %0d actual %0d", $time, g.status,
                     rsp.status);
            errors++;
          end
          if (rsp.data_offset !== g.offset) begin
            $display("%0t: data_offset expected %0h actual %0h", $time,
                     g.offset, rsp.data_offset);
            errors++;
          end
          case (g.status)
            ST_OK:        n_ok++;
            ST_NO_FIT:    n_nofit++;
            default:      n_notfound++;
          endcase
        end
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || sent_cnt != taken_cnt ||
           expected_grants.size() > 0)
      @(posedge clk);
    repeat (PARTS + 10) @(posedge clk);
  endtask

  task automatic write_heap(input logic [20:0] value);
    @(negedge clk);
    cfg.data  <= value;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    reset_table(value);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic push_req(input logic op, input int unsigned size,
                          input int unsigned addr);
    heap_req_t r;
    r.op   = op;
    r.size = 21'(size);
    r.addr = 20'(addr);
    pending_reqs.push_back(r);
    if (op == OP_FREE) n_frees++;
  endtask

  // one random request shaped by the current table
  task automatic push_random();
    int unsigned k, sz, ad;
    while (pending_reqs.size() >= 4) @(posedge clk);
    k = $urandom_range(0, 99);
    if (k < 55) begin
      k = $urandom_range(0, 99);
      if (k < 60)      sz = $urandom_range(0, 64);
      else if (k < 85) sz = $urandom_range(0, heap_bytes / 4);
      else if (k < 95) sz = $urandom_range(0, heap_bytes);
      else             sz = $urandom() & 32'h1FFFFF;
      push_req(OP_ALLOC, sz, $urandom());
    end else begin
      k = $urandom_range(0, 99);
      if (k < 75)      ad = tbl_start[$urandom_range(0, tbl_count - 1)] + HDR;
      else if (k < 90) ad = $urandom_range(0, 256);
      else             ad = $urandom() & 32'hFFFFF;
      push_req(OP_FREE, $urandom(), ad);
    end
  endtask

  initial begin
    int unsigned heaps [8];
    req.valid = 1'b0;
    req.op = OP_ALLOC;
    req.request_size = '0;
    req.block_address = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    reset_table(HEAP_RESET);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero, odd and exact sizes, free cases, extremes
    push_req(OP_ALLOC, 0, 0);
    push_req(OP_ALLOC, 1, 0);
    push_req(OP_ALLOC, 3, 0);
    push_req(OP_ALLOC, 4, 0);
    push_req(OP_ALLOC, 5, 0);
    push_req(OP_FREE, 0, HDR);
    push_req(OP_FREE, 0, HDR);
    push_req(OP_FREE, 0, 3);
    push_req(OP_FREE, 21'h1FFFFF, 20'hFFFFF);
    push_req(OP_ALLOC, 21'h1FFFFF, 20'hFFFFF);
    push_req(OP_ALLOC, 0, HDR);
    push_req(OP_ALLOC, 2000, 0);
    push_req(OP_ALLOC, 4096, 0);
    push_req(OP_ALLOC, 100000, 0);
    drain();
    // smallest heap, then the whole data area in one request
    write_heap(21'd64);
    push_req(OP_ALLOC, 4, 0);
    push_req(OP_ALLOC, 4, 0);
    push_req(OP_ALLOC, 4, 0);
    push_req(OP_ALLOC, 4, 0);
    drain();
    write_heap(21'd1048576);
    push_req(OP_ALLOC, 1048576 - HDR, 0);
    push_req(OP_ALLOC, 0, 0);
    drain();

    heaps = '{4096, 0, 1048576, 21'h1FFFFF, 200, 1000, 65536, 512};
    for (int p = 0; p < 8; p++) begin
      if (p == 3) heaps[p] = $urandom_range(64, 16384);
      write_heap(21'(heaps[p]));
      calm = (p == 7);
      for (int n = 0; n < 100; n++) begin
        if (p == 2 && n == 20) hold_trigger = 1'b1;
        push_random();
      end
      drain();
    end
    write_heap(21'(HEAP_RESET));

    $display("Covered %0d grants, %0d no-fit, %0d unknown frees, %0d frees issued,",
             n_ok, n_nofit, n_notfound, n_frees);
    $display("%0d full-table grants, over eleven heap sizes incl. clamped writes.",
             n_full);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
design/wfpa_pkg.sv
design/wfpa_if.sv
design/wfpa_cell.sv
design/worst_fit_partition_allocator.sv
tb/worst_fit_partition_allocator_test.sv
